// ===== rtl/bitmask_code_decompressor_top_defines.svh =====
// assertion macros for the top-level rtl
`ifndef BITMASK_CODE_DECOMPRESSOR_TOP_DEFINES_SVH
`define BITMASK_CODE_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BMCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BMCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmcd_pkg.sv =====
`default_nettype none

package bmcd_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_DICT = 8;
  localparam int CFG_IDX_W = 4;

  typedef logic [NUM_DICT-1:0][WORD_W-1:0] dict_array_t;

  typedef enum logic [2:0] {
    FMT_REPEAT  = 3'd0,
    FMT_MASK    = 3'd1,
    FMT_FLIP1   = 3'd2,
    FMT_FLIP2ADJ = 3'd3,
    FMT_FLIP2   = 3'd4,
    FMT_DICT    = 3'd5,
    FMT_RAW     = 3'd6,
    FMT_END     = 3'd7
  } fmt_t;

  // everything the word rebuild needs besides the final field
  typedef struct packed {
    fmt_t       fmt;
    logic [4:0] first_pos;
    logic [4:0] second_pos;
    logic [3:0] mask;
  } record_t;

  // width of field ph (1..3) of a record, zero where the record has no such field
  function automatic logic [5:0] field_width(fmt_t f, logic [1:0] ph);
    logic [5:0] w;
    w = 6'd0;
    case (f)
      FMT_REPEAT:   w = (ph == 2'd1) ? 6'd2 : 6'd0;
      FMT_MASK: begin
        case (ph)
          2'd1:    w = 6'd5;
          2'd2:    w = 6'd4;
          2'd3:    w = 6'd3;
          default: w = 6'd0;
        endcase
      end
      FMT_FLIP1, FMT_FLIP2ADJ: begin
        case (ph)
          2'd1:    w = 6'd5;
          2'd2:    w = 6'd3;
          default: w = 6'd0;
        endcase
      end
      FMT_FLIP2: begin
        case (ph)
          2'd1:    w = 6'd5;
          2'd2:    w = 6'd5;
          2'd3:    w = 6'd3;
          default: w = 6'd0;
        endcase
      end
      FMT_DICT:     w = (ph == 2'd1) ? 6'd3 : 6'd0;
      FMT_RAW:      w = (ph == 2'd1) ? 6'd32 : 6'd0;
      default:      w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bmcd_rebuild.sv =====
`default_nettype none

module bmcd_rebuild (
  input  var bmcd_pkg::record_t     rec,
  input  wire [31:0]                field_val,
  input  var bmcd_pkg::dict_array_t dict,
  input  wire [31:0]                last_word,
  output logic [31:0]               word
);
  import bmcd_pkg::*;

  localparam logic [31:0] TOP_BIT = 32'h8000_0000;

  logic [31:0] base;
  logic [31:0] flip;

  // position p names bit 31-p; bits shifted below bit 0 are dropped
  always_comb begin
    base = dict[field_val[2:0]];
    case (rec.fmt)
      FMT_MASK:     flip = {rec.mask, 28'd0} >> rec.first_pos;
      FMT_FLIP1:    flip = TOP_BIT >> rec.first_pos;
      FMT_FLIP2ADJ: flip = {2'b11, 30'd0} >> rec.first_pos;
      FMT_FLIP2:    flip = (TOP_BIT >> rec.first_pos) | (TOP_BIT >> rec.second_pos);
      default:      flip = 32'd0;
    endcase
    case (rec.fmt)
      FMT_REPEAT: word = last_word;
      FMT_RAW:    word = field_val;
      default:    word = base ^ flip;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bitmask_code_decompressor_top.sv =====
`default_nettype none
// Bitmask code decompressor: takes the compressed stream one bit per word on
// the in_ channel and rebuilds 32-bit instruction words on the out_ channel.
// Each record is a 3-bit format code followed by its fields, msb first:
// repeat last word (2-bit count, count+1 words), mask xor (5-bit position,
// 4-bit mask, 3-bit index), one-bit flip, two adjacent bits flipped,
// two separate flips, plain dictionary word, 32 raw bits, and end of
// stream, after which bits are taken and ignored until reset. Position p
// names bit 31-p. The eight dictionary words are written through cfg_
// (index 0..7, other indexes ignored); the user must write them only while
// the block is idle, which the block itself does not enforce. All reset to
// zero. Rate: one stream bit per cycle. Only the bit that completes a record
// produces words; it is held off until the single output register is empty
// or handing over its final word. Every record is at least five bits long,
// so a repeat run of up to four words has drained before the next completing
// bit arrives, and with out_ready held high the input never stalls; only
// back-pressure on out_ holds it. The first word is out in the next cycle.
module bitmask_code_decompressor_top (
  input  wire                             clk,
  input  wire                             rst_n,
  // compressed bit stream
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_stream_bit,
  // rebuilt words
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [31:0]                     out_word_out,
  output logic                            out_run_last,
  // dictionary writes
  input  wire                             cfg_we,
  input  wire [bmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [31:0]                      cfg_wdata
);
  import bmcd_pkg::*;
  `include "bitmask_code_decompressor_top_defines.svh"

  // parser state
  logic [31:0] shift_r, shift_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  fmt_t        fmt_r, fmt_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  pos1_r, pos1_nxt;
  logic [4:0]  pos2_r, pos2_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic        ended_r, ended_nxt;
  logic [31:0] last_word_r;

  // dictionary
  dict_array_t dict_r;

  // output register and repeat count still to send after the current word
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_last_r;
  logic [1:0]  rep_r;

  logic [31:0] shift_in;
  logic [5:0]  cnt_inc;
  logic [5:0]  cur_width;
  logic        field_done;
  logic        last_fld;
  logic        emit_due;
  logic        emit;
  logic        slot_free;
  logic        in_fire;
  logic [1:0]  rep_load;
  logic [31:0] word;
  record_t     rec;

  assign shift_in  = {shift_r[30:0], in_stream_bit};
  assign cnt_inc   = cnt_r + 6'd1;
  assign cur_width = field_width(fmt_r, phase_r);
  // the final field of a record: third field, or no field after this one
  assign last_fld  = (phase_r == 2'd3) || (field_width(fmt_r, phase_r + 2'd1) == 6'd0);
  assign field_done = (phase_r == 2'd0) ? (cnt_inc == 6'd3) : (cnt_inc == cur_width);

  // whether the next bit produces words does not depend on its value
  assign emit_due  = !ended_r && (phase_r != 2'd0) && field_done && last_fld;
  assign slot_free = !out_valid_r || (out_ready && out_last_r);
  assign in_ready  = !emit_due || slot_free;
  assign in_fire   = in_valid && in_ready;
  assign emit      = in_fire && emit_due;

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    fmt_nxt   = fmt_r;
    phase_nxt = phase_r;
    pos1_nxt  = pos1_r;
    pos2_nxt  = pos2_r;
    mask_nxt  = mask_r;
    ended_nxt = ended_r;
    if (in_fire && !ended_r) begin
      shift_nxt = shift_in;
      cnt_nxt   = cnt_inc;
      if (field_done) begin
        shift_nxt = 32'd0;
        cnt_nxt   = 6'd0;
        if (phase_r == 2'd0) begin
          fmt_nxt = fmt_t'(shift_in[2:0]);
          if (fmt_t'(shift_in[2:0]) == FMT_END) begin
            ended_nxt = 1'b1;
          end else begin
            phase_nxt = 2'd1;
          end
        end else if (last_fld) begin
          phase_nxt = 2'd0;
        end else begin
          if (phase_r == 2'd1) begin
            pos1_nxt = shift_in[4:0];
          end else if (fmt_r == FMT_MASK) begin
            mask_nxt = shift_in[3:0];
          end else begin
            pos2_nxt = shift_in[4:0];
          end
          phase_nxt = phase_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    rec.fmt        = fmt_r;
    rec.first_pos  = pos1_r;
    rec.second_pos = pos2_r;
    rec.mask       = mask_r;
    rep_load       = (fmt_r == FMT_REPEAT) ? shift_in[1:0] : 2'd0;
  end

  bmcd_rebuild u_rebuild (
    .rec       (rec),
    .field_val (shift_in),
    .dict      (dict_r),
    .last_word (last_word_r),
    .word      (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 32'd0;
      cnt_r       <= 6'd0;
      fmt_r       <= FMT_REPEAT;
      phase_r     <= 2'd0;
      pos1_r      <= 5'd0;
      pos2_r      <= 5'd0;
      mask_r      <= 4'd0;
      ended_r     <= 1'b0;
      last_word_r <= 32'd0;
    end else begin
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      fmt_r   <= fmt_nxt;
      phase_r <= phase_nxt;
      pos1_r  <= pos1_nxt;
      pos2_r  <= pos2_nxt;
      mask_r  <= mask_nxt;
      ended_r <= ended_nxt;
      // a repeat leaves the last word as it is
      if (emit && (fmt_r != FMT_REPEAT)) begin
        last_word_r <= word;
      end
    end
  end

  // dictionary write port, out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        4'd0:    dict_r[0] <= cfg_wdata;
        4'd1:    dict_r[1] <= cfg_wdata;
        4'd2:    dict_r[2] <= cfg_wdata;
        4'd3:    dict_r[3] <= cfg_wdata;
        4'd4:    dict_r[4] <= cfg_wdata;
        4'd5:    dict_r[5] <= cfg_wdata;
        4'd6:    dict_r[6] <= cfg_wdata;
        4'd7:    dict_r[7] <= cfg_wdata;
        default: dict_r <= dict_r;
      endcase
    end
  end

  // output register: a repeat run replays the held word, counting down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      rep_r       <= 2'd0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      rep_r       <= rep_load;
      out_last_r  <= (rep_load == 2'd0);
    end else if (out_valid_r && out_ready) begin
      if (out_last_r) begin
        out_valid_r <= 1'b0;
      end else begin
        rep_r      <= rep_r - 2'd1;
        out_last_r <= (rep_r == 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= word;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_run_last = out_last_r;

  `BMCD_ASSERT_NEXT(a_end_sticky, ended_r, ended_r, "end of stream flag dropped")
  `BMCD_ASSERT_NOW(a_rep_pending, out_valid_r && !out_last_r, rep_r != 2'd0, "run not marked last with no repeats left")
  `BMCD_ASSERT_NOW(a_no_end_record, phase_r != 2'd0, fmt_r != FMT_END, "fields parsed after end-of-stream code")
  `BMCD_ASSERT_NOW(a_ended_drains, ended_r, in_ready && !emit, "input stalled or words made after end of stream")

endmodule

`default_nettype wire

// ===== bench/bitmask_code_decompressor_top_tb.sv =====
`timescale 1ns / 1ps

module bitmask_code_decompressor_top_tb;
  import bmcd_pkg::*;

  // no handshake on either side for this long means the block is hung
  localparam int STALL_LIMIT   = 2000;
  // cycles allowed after the last word before touching the dictionary or ending
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [31:0] word;
    logic        run_last;
  } word_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stream_bit = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [31:0]          out_word_out;
  wire                  out_run_last;

  bitmask_code_decompressor_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_stream_bit (in_stream_bit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word_out  (out_word_out),
    .out_run_last  (out_run_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // decoder mirror: dictionary copy plus the bit-serial record parser state
  logic [31:0] dict_mirror [NUM_DICT];
  logic [31:0] fld_shift = '0;
  int          fld_cnt = 0;
  fmt_t        cur_fmt = FMT_REPEAT;
  int          rec_phase = 0;
  logic [4:0]  pos_a = '0;
  logic [4:0]  pos_b = '0;
  logic [3:0]  mask4 = '0;
  logic [31:0] prev_word = '0;
  bit          stream_done = 1'b0;

  word_exp_t   pending_words [$];
  word_exp_t   head;
  int          errors = 0;
  int          bits_sent = 0;
  int          words_expected = 0;
  int          idle_cycles = 0;
  int unsigned ready_hold = 0;
  // when set, neither side inserts gaps
  bit          quiet = 1'b0;

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // bits in field ph of a record, zero past its last field
  function automatic int field_bits(fmt_t f, int ph);
    case (f)
      FMT_REPEAT:              return (ph == 1) ? 2 : 0;
      FMT_MASK:                return (ph == 1) ? 5 : (ph == 2) ? 4 : (ph == 3) ? 3 : 0;
      FMT_FLIP1, FMT_FLIP2ADJ: return (ph == 1) ? 5 : (ph == 2) ? 3 : 0;
      FMT_FLIP2:               return (ph == 1 || ph == 2) ? 5 : (ph == 3) ? 3 : 0;
      FMT_DICT:                return (ph == 1) ? 3 : 0;
      FMT_RAW:                 return (ph == 1) ? 32 : 0;
      default:                 return 0;
    endcase
  endfunction

  // xor pattern of a record; position p names bit 31-p, bits pushed past bit 0 fall off
  function automatic logic [31:0] flip_mask(fmt_t f);
    logic [35:0] wide;
    case (f)
      FMT_MASK: begin
        wide = {mask4, 32'b0} >> (pos_a + 4);
        return wide[31:0];
      end
      FMT_FLIP1:    return 32'h8000_0000 >> pos_a;
      FMT_FLIP2ADJ: begin
        wide = {4'b0011, 32'b0} >> (pos_a + 2);
        return wide[31:0];
      end
      // equal positions flip the same bit once
      FMT_FLIP2:    return (32'h8000_0000 >> pos_a) | (32'h8000_0000 >> pos_b);
      default:      return '0;
    endcase
  endfunction

  function automatic void expect_word(input logic [31:0] w, input logic last);
    word_exp_t e;
    e.word = w;
    e.run_last = last;
    pending_words = {pending_words, e};
    words_expected++;
  endfunction

  // advance the mirror by one accepted stream bit, queueing any rebuilt words
  function automatic void decode_bit(input logic b);
    logic [31:0] val;
    int          reps;
    int          k;
    if (stream_done) return;
    fld_shift = {fld_shift[30:0], b};
    fld_cnt++;
    if (rec_phase == 0) begin
      if (fld_cnt < 3) return;
      cur_fmt = fmt_t'(fld_shift[2:0]);
      fld_shift = '0;
      fld_cnt = 0;
      // end of stream: everything after is dropped until reset
      if (cur_fmt == FMT_END) stream_done = 1'b1;
      else rec_phase = 1;
      return;
    end
    if (fld_cnt < field_bits(cur_fmt, rec_phase)) return;
    val = fld_shift;
    fld_shift = '0;
    fld_cnt = 0;
    if (field_bits(cur_fmt, rec_phase + 1) != 0) begin
      if (rec_phase == 1) pos_a = val[4:0];
      else if (cur_fmt == FMT_MASK) mask4 = val[3:0];
      else pos_b = val[4:0];
      rec_phase++;
      return;
    end
    // final field: the record completes here
    rec_phase = 0;
    case (cur_fmt)
      FMT_REPEAT: begin
        reps = int'(val[1:0]) + 1;
        for (k = 0; k < reps; k++) expect_word(prev_word, k == reps - 1);
      end
      FMT_RAW: begin
        prev_word = val;
        expect_word(prev_word, 1'b1);
      end
      default: begin
        prev_word = dict_mirror[val[2:0]] ^ flip_mask(cur_fmt);
        expect_word(prev_word, 1'b1);
      end
    endcase
  endfunction

  // receiver side: random back-pressure on the word channel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // word checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h run_last %b",
                 $time, out_word_out, out_run_last);
      end else begin
        head = pending_words.pop_front();
        if (head.word !== out_word_out) begin
          errors++;
          $display("%0t: word mismatch, expected %h, got %h", $time, head.word, out_word_out);
        end
        if (head.run_last !== out_run_last) begin
          errors++;
          $display("%0t: run_last mismatch, expected %b, got %b",
                   $time, head.run_last, out_run_last);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one stream bit; valid is left high after acceptance so back-to-back bits
  // need no extra edge, a gap or a drain lowers it in the same step
  task automatic send_bit(input logic b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_bit <= b;
    do @(posedge clk); while (!in_ready);
    decode_bit(b);
    bits_sent++;
  endtask

  task automatic send_field(input logic [31:0] v, input int w);
    int i;
    for (i = w - 1; i >= 0; i--) send_bit(v[i]);
  endtask

  // payload carries the repeat count or the raw word
  task automatic send_record(input fmt_t f, input logic [4:0] pa, input logic [4:0] pb,
                             input logic [3:0] m, input logic [2:0] idx,
                             input logic [31:0] payload);
    send_field(32'(f), 3);
    case (f)
      FMT_REPEAT: send_field(payload, 2);
      FMT_MASK: begin
        send_field(32'(pa), 5);
        send_field(32'(m), 4);
        send_field(32'(idx), 3);
      end
      FMT_FLIP1, FMT_FLIP2ADJ: begin
        send_field(32'(pa), 5);
        send_field(32'(idx), 3);
      end
      FMT_FLIP2: begin
        send_field(32'(pa), 5);
        send_field(32'(pb), 5);
        send_field(32'(idx), 3);
      end
      FMT_DICT: send_field(32'(idx), 3);
      FMT_RAW:  send_field(payload, 32);
      default: ;
    endcase
  endtask

  // positions near the low end are where mask bits fall off
  function automatic logic [4:0] rand_position();
    logic [4:0] edges [5];
    edges = '{5'd0, 5'd28, 5'd29, 5'd30, 5'd31};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 4)];
    return 5'($urandom);
  endfunction

  task automatic send_random_record();
    int unsigned pick;
    fmt_t        f;
    logic [4:0]  pa;
    logic [4:0]  pb;
    // occasional stretch with no gaps on either side
    quiet = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 20) f = FMT_REPEAT;
    else if (pick < 36) f = FMT_MASK;
    else if (pick < 50) f = FMT_FLIP1;
    else if (pick < 64) f = FMT_FLIP2ADJ;
    else if (pick < 78) f = FMT_FLIP2;
    else if (pick < 92) f = FMT_DICT;
    else f = FMT_RAW;
    pa = rand_position();
    pb = ($urandom_range(0, 9) == 0) ? pa : rand_position();
    send_record(f, pa, pb, 4'($urandom), 3'($urandom), $urandom);
    quiet = 1'b0;
  endtask

  // stop sending and wait for every predicted word, plus SETTLE_CYCLES for a
  // completing bit that may still be in flight
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all eight entries, then one write to an unused index that must be dropped
  task automatic program_dict(input bit scramble, input logic [31:0] fill);
    int i;
    for (i = 0; i < NUM_DICT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= scramble ? $urandom : fill;
      @(posedge clk);
      dict_mirror[i] = cfg_wdata;
    end
    cfg_index <= CFG_IDX_W'($urandom_range(NUM_DICT, 2 ** CFG_IDX_W - 1));
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // repeat before any word rebuilt: last word is still zero
  task automatic test_repeat_from_reset();
    send_record(FMT_REPEAT, '0, '0, '0, '0, 32'd0);
    send_record(FMT_REPEAT, '0, '0, '0, '0, 32'd3);
  endtask

  // every format but end of stream, mostly at the position extremes
  task automatic test_every_format();
    send_record(FMT_MASK,     5'd0,  '0,    4'hf, 3'd0, '0);
    // mask partly shifted past bit 0
    send_record(FMT_MASK,     5'd29, '0,    4'hf, 3'd2, '0);
    send_record(FMT_MASK,     5'd31, '0,    4'hf, 3'd3, '0);
    send_record(FMT_FLIP1,    5'd31, '0,    '0,   3'd4, '0);
    send_record(FMT_FLIP2ADJ, 5'd30, '0,    '0,   3'd6, '0);
    // adjacent pair at the last position: only bit 0 flips
    send_record(FMT_FLIP2ADJ, 5'd31, '0,    '0,   3'd6, '0);
    // same position twice flips one bit once
    send_record(FMT_FLIP2,    5'd7,  5'd7,  '0,   3'd1, '0);
    send_record(FMT_FLIP2,    5'd0,  5'd31, '0,   3'd2, '0);
    send_record(FMT_DICT,     '0,    '0,    '0,   3'd7, '0);
    send_record(FMT_RAW,      '0,    '0,    '0,   '0,   32'hffff_ffff);
    send_record(FMT_REPEAT,   '0,    '0,    '0,   '0,   32'd3);
  endtask

  // full rate on both sides: repeat runs and plain words back to back
  task automatic test_back_to_back();
    quiet = 1'b1;
    send_record(FMT_REPEAT, '0, '0, '0, '0, 32'd3);
    send_record(FMT_REPEAT, '0, '0, '0, '0, 32'd2);
    send_record(FMT_DICT,   '0, '0, '0, 3'd5, '0);
    send_record(FMT_REPEAT, '0, '0, '0, '0, 32'd3);
    quiet = 1'b0;
  endtask

  // sender goes silent until everything predicted has come out
  task automatic test_pause_until_drained();
    send_random_record();
    send_random_record();
    drain_words();
    send_random_record();
  endtask

  task automatic test_random_stream(input int min_bits, input int min_words);
    int bits0;
    int words0;
    bits0 = bits_sent;
    words0 = words_expected;
    while (bits_sent - bits0 < min_bits || words_expected - words0 < min_words)
      send_random_record();
  endtask

  // end record, then bits and a whole record that must all be swallowed
  task automatic test_end_of_stream();
    int i;
    send_record(FMT_END, '0, '0, '0, '0, '0);
    for (i = 0; i < 8; i++) send_bit(1'($urandom_range(0, 1)));
    send_record(FMT_DICT, '0, '0, '0, 3'd3, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    program_dict(1'b1, '0);
    test_repeat_from_reset();
    test_every_format();
    test_back_to_back();
    test_pause_until_drained();

    // dictionary at all ones
    drain_words();
    program_dict(1'b0, 32'hffff_ffff);
    test_random_stream(12, 1);

    // dictionary at all zeros
    drain_words();
    program_dict(1'b0, 32'h0000_0000);
    test_random_stream(12, 1);

    // fresh random dictionary
    drain_words();
    program_dict(1'b1, '0);
    test_random_stream(12, 1);

    test_end_of_stream();
    drain_words();

    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
